### hw/rtl/sdtq_pkg.sv
// Shared types and constants for the sorted deadline timer queue.
// No dependencies; imported by sdtq_cell and sorted_deadline_timer_queue.
package sdtq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DL_W        = 32;
  localparam int RSN_W       = 8;
  localparam int IVL_W       = 31;
  localparam int CMP_W       = 16;
  localparam int ENTRY_W     = 5;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STOP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  // Broadcast to every cell during the execute cycle.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [DL_W-1:0]  dl;
    logic [RSN_W-1:0] rsn;
  } cell_cmd_t;

endpackage

### hw/rtl/sdtq_cell.sv
// One slot of the sorted timer chain: holds a deadline and a reason tag.
// Depends on sdtq_pkg; instantiated QUEUE_DEPTH times by the top level.
module sdtq_cell
  import sdtq_pkg::*;
(
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic             occ,
  input  logic             gt_prev,
  input  logic [DL_W-1:0]  left_dl,
  input  logic [RSN_W-1:0] left_rsn,
  input  logic [DL_W-1:0]  right_dl,
  input  logic [RSN_W-1:0] right_rsn,
  input  logic             hit_in,
  output logic [DL_W-1:0]  dl,
  output logic [RSN_W-1:0] rsn,
  output logic             gt,
  output logic             hit_out
);

  logic [DL_W-1:0]  dl_r,  dl_nxt;
  logic [RSN_W-1:0] rsn_r, rsn_nxt;

  // The slot moves aside for a new deadline unless it holds an equal or earlier one.
  assign gt      = !(occ && (dl_r <= cmd.dl));
  assign hit_out = hit_in || (occ && (rsn_r == cmd.rsn));

  always_comb begin
    dl_nxt  = dl_r;
    rsn_nxt = rsn_r;
    if (cmd.ins && gt) begin
      dl_nxt  = gt_prev ? left_dl  : cmd.dl;
      rsn_nxt = gt_prev ? left_rsn : cmd.rsn;
    end else if (cmd.rem && hit_out) begin
      dl_nxt  = right_dl;
      rsn_nxt = right_rsn;
    end
  end

  always_ff @(posedge clk) begin
    dl_r  <= dl_nxt;
    rsn_r <= rsn_nxt;
  end

  assign dl  = dl_r;
  assign rsn = rsn_r;

endmodule

### hw/rtl/sorted_deadline_timer_queue.sv
// Top level of the sorted deadline timer queue: control, counters, result register.
// Depends on sdtq_pkg and instantiates a chain of sdtq_cell slots.
//
// Usage: each input word is either a timer start (mode 0) or a timer stop
// (mode 1). A start computes the deadline as interval times two plus now,
// wrapping at 32 bits, and files it after every pending timer with an equal
// or earlier deadline. A stop removes the earliest pending timer whose reason
// tag matches. Each input word yields exactly one output word with a status,
// the compare register (low 16 bits of the head deadline), the compare enable
// and the number of pending timers.
// Operation: the item is registered at accept and the deadline is formed with
// one 32-bit add; in the execute cycle every cell compares in parallel and
// shifts toward or away from its neighbor, and the output register loads.
// The input is stalled during the execute cycle, so the block takes no new
// word until the previous one has executed.
// Stalls: the result sits in an output register, so a new word is accepted
// while an earlier result waits. If the output is still stalled when the
// next item reaches its execute cycle, execution holds until the register
// frees up, and the input stays stalled meanwhile.
// Reset: rst_n (synchronous, active low) empties the queue, clears the
// compare register and enable, and drops out_valid. Cell contents are not
// reset; a cell is only read once the pending count covers it.
module sorted_deadline_timer_queue
  import sdtq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [RSN_W-1:0]   in_reason,
  input  logic [IVL_W-1:0]   in_interval,
  input  logic [DL_W-1:0]    in_now,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [CMP_W-1:0]   out_compare_value,
  output logic               out_compare_enable,
  output logic [ENTRY_W-1:0] out_entry_count
);

  fsm_t state_r, state_nxt;
  logic exec_go;

  // Item registered at accept; the deadline is formed here so that the
  // execute cycle only sees compares.
  logic             mode_r;
  logic [RSN_W-1:0] rsn_r;
  logic [DL_W-1:0]  dl_r;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CMP_W-1:0] cmp_r, cmp_nxt;
  logic             cmp_on_r, cmp_on_nxt;
  status_t          status_nxt;

  logic               out_valid_r;
  status_t            out_status_r;
  logic [CMP_W-1:0]   out_cmp_r;
  logic               out_cmp_on_r;
  logic [ENTRY_W-1:0] out_count_r;

  logic [DL_W-1:0]  cell_dl  [QUEUE_DEPTH];
  logic [RSN_W-1:0] cell_rsn [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] occ;
  logic [QUEUE_DEPTH-1:0] gt;
  logic [QUEUE_DEPTH:0]   hit;
  cell_cmd_t cmd;

  logic full, found;

  assign in_stall = (state_r == FSM_EXEC);

  // Sequencer: idle until a word is accepted, then an execute state that
  // waits only while the previous result is still unclaimed.
  always_comb begin
    state_nxt = state_r;
    exec_go   = 1'b0;
    case (state_r)
      FSM_IDLE: begin
        if (in_valid) begin
          state_nxt = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (!(out_valid_r && out_stall)) begin
          exec_go   = 1'b1;
          state_nxt = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      mode_r <= in_mode;
      rsn_r  <= in_reason;
      dl_r   <= DL_W'({in_interval, 1'b0}) + in_now;
    end
  end

  // Occupancy comes straight from the pending count: the queue is packed at
  // the low end of the chain.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_occ
    assign occ[i] = (CNT_W'(i) < count_r);
  end

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign found = hit[QUEUE_DEPTH];

  assign cmd.ins = exec_go && (mode_r == MODE_START) && !full;
  assign cmd.rem = exec_go && (mode_r == MODE_STOP) && found;
  assign cmd.dl  = dl_r;
  assign cmd.rsn = rsn_r;

  // The first-match flag ripples from the head toward the tail; every cell
  // at or behind the match pulls its right neighbor in on a stop, and every
  // cell behind the insertion point pulls its left neighbor in on a start.
  assign hit[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic             gt_prev;
    logic [DL_W-1:0]  left_dl, right_dl;
    logic [RSN_W-1:0] left_rsn, right_rsn;

    if (i == 0) begin : g_head
      assign gt_prev  = 1'b0;
      assign left_dl  = dl_r;
      assign left_rsn = rsn_r;
    end else begin : g_body
      assign gt_prev  = gt[i-1];
      assign left_dl  = cell_dl[i-1];
      assign left_rsn = cell_rsn[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_dl  = dl_r;
      assign right_rsn = rsn_r;
    end else begin : g_inner
      assign right_dl  = cell_dl[i+1];
      assign right_rsn = cell_rsn[i+1];
    end

    sdtq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ[i]),
      .gt_prev   (gt_prev),
      .left_dl   (left_dl),
      .left_rsn  (left_rsn),
      .right_dl  (right_dl),
      .right_rsn (right_rsn),
      .hit_in    (hit[i]),
      .dl        (cell_dl[i]),
      .rsn       (cell_rsn[i]),
      .gt        (gt[i]),
      .hit_out   (hit[i+1])
    );
  end

  // Count, compare register and status for the item in execution.
  always_comb begin
    count_nxt  = count_r;
    cmp_nxt    = cmp_r;
    cmp_on_nxt = cmp_on_r;
    status_nxt = ST_OK;
    if (mode_r == MODE_START) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        // A new deadline that lands in the head slot reprograms the compare.
        if (gt[0]) begin
          cmp_nxt    = dl_r[CMP_W-1:0];
          cmp_on_nxt = 1'b1;
        end
      end
    end else begin
      if (!found) begin
        status_nxt = ST_NOT_FOUND;
      end else begin
        count_nxt = count_r - CNT_W'(1);
        // Removing the head hands the compare to the next entry, or turns
        // the interrupt off when the queue drains.
        if (hit[1]) begin
          if (count_r == CNT_W'(1)) begin
            cmp_on_nxt = 1'b0;
          end else begin
            cmp_nxt = cell_dl[1][CMP_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cmp_r    <= '0;
      cmp_on_r <= 1'b0;
    end else if (exec_go) begin
      count_r  <= count_nxt;
      cmp_r    <= cmp_nxt;
      cmp_on_r <= cmp_on_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_status_r <= status_nxt;
      out_cmp_r    <= cmp_nxt;
      out_cmp_on_r <= cmp_on_nxt;
      out_count_r  <= ENTRY_W'(count_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_compare_value  = out_cmp_r;
  assign out_compare_enable = out_cmp_on_r;
  assign out_entry_count    = out_count_r;

  // The pending count never runs past the depth of the chain.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("pending count exceeds queue depth");

  // The compare interrupt is enabled exactly while timers are pending.
  a_cmp_on_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_on_r == (count_r != '0))
    else $error("compare enable out of step with pending count");

  // Execution never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !exec_go)
    else $error("result register overwritten while stalled");

  // Every accepted word is executed in the following cycle or held there.
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == FSM_EXEC))
    else $error("accepted word did not reach execution");

endmodule

### bench/tb.sv
// Self-checking bench for sorted_deadline_timer_queue: a deadline ledger class tracks
// the pending timers and checks every output word, while plain tasks drive the ports.
// Depends on sdtq_pkg and the sorted_deadline_timer_queue RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sdtq_pkg::*;

  // One output word as the block reports it.
  typedef struct packed {
    logic [1:0]         status;
    logic [CMP_W-1:0]   cmp;
    logic               en;
    logic [ENTRY_W-1:0] cnt;
  } timer_word_t;

  // Mirror of the timer queue. book() files an accepted input word and queues the
  // output word it must produce; check() retires the oldest one against the block.
  class deadline_ledger;
    logic [DL_W-1:0]  deadline [QUEUE_DEPTH];
    logic [RSN_W-1:0] tag [QUEUE_DEPTH];
    int               depth_now;
    logic [CMP_W-1:0] cmp_reg;
    logic             cmp_on;
    timer_word_t      awaited [$];
    int               faults;
    int               checked;

    function new();
      depth_now = 0;
      cmp_reg   = '0;
      cmp_on    = 1'b0;
      faults    = 0;
      checked   = 0;
    endfunction

    function void book(logic mode, logic [RSN_W-1:0] rsn, logic [IVL_W-1:0] ivl,
                       logic [DL_W-1:0] now);
      logic [DL_W-1:0] dl;
      int              pos;
      timer_word_t     w;
      pos = 0;
      if (mode == MODE_START) begin
        if (depth_now >= QUEUE_DEPTH) begin
          w.status = ST_FULL;
        end else begin
          dl = {ivl, 1'b0} + now;
          while (pos < depth_now && deadline[pos] <= dl) pos++;
          for (int k = depth_now; k > pos; k--) begin
            deadline[k] = deadline[k-1];
            tag[k]      = tag[k-1];
          end
          deadline[pos] = dl;
          tag[pos]      = rsn;
          depth_now++;
          if (pos == 0) begin
            cmp_reg = dl[CMP_W-1:0];
            cmp_on  = 1'b1;
          end
          w.status = ST_OK;
        end
      end else begin
        while (pos < depth_now && tag[pos] != rsn) pos++;
        if (pos >= depth_now) begin
          w.status = ST_NOT_FOUND;
        end else begin
          for (int k = pos; k + 1 < depth_now; k++) begin
            deadline[k] = deadline[k+1];
            tag[k]      = tag[k+1];
          end
          depth_now--;
          if (pos == 0) begin
            if (depth_now == 0) begin
              cmp_on = 1'b0;
            end else begin
              cmp_reg = deadline[0][CMP_W-1:0];
              cmp_on  = 1'b1;
            end
          end
          w.status = ST_OK;
        end
      end
      w.cmp = cmp_reg;
      w.en  = cmp_on;
      w.cnt = ENTRY_W'(depth_now);
      awaited.push_back(w);
    endfunction

    function void fault(string what);
      faults++;
      if (faults <= 10) $display("mismatch: %s", what);
    endfunction

    function void check(timer_word_t got);
      timer_word_t want;
      checked++;
      if (awaited.size() == 0) begin
        fault($sformatf("output word %0d arrived with none pending: %p", checked, got));
        return;
      end
      want = awaited.pop_front();
      if (got.status != want.status)
        fault($sformatf("word %0d status exp %0d got %0d", checked, want.status, got.status));
      if (got.cmp != want.cmp)
        fault($sformatf("word %0d compare_value exp %h got %h", checked, want.cmp, got.cmp));
      if (got.en != want.en)
        fault($sformatf("word %0d compare_enable exp %b got %b", checked, want.en, got.en));
      if (got.cnt != want.cnt)
        fault($sformatf("word %0d entry_count exp %0d got %0d", checked, want.cnt, got.cnt));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_mode;
  logic [RSN_W-1:0]   in_reason;
  logic [IVL_W-1:0]   in_interval;
  logic [DL_W-1:0]    in_now;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic [CMP_W-1:0]   out_compare_value;
  logic               out_compare_enable;
  logic [ENTRY_W-1:0] out_entry_count;

  deadline_ledger ledger = new();

  // When calm is set, neither side idles; this covers the closing stretch of the run.
  bit calm;
  // Chance, in percent, of an idle burst after a word (sender) or per cycle (receiver).
  int idle_pct;
  int stall_pct;
  int hold_left;
  int cycle_cnt;

  sorted_deadline_timer_queue dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_reason         (in_reason),
    .in_interval       (in_interval),
    .in_now            (in_now),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_compare_value (out_compare_value),
    .out_compare_enable(out_compare_enable),
    .out_entry_count   (out_entry_count)
  );

  always #4 clk = ~clk;

  // Receiver side. Stall comes in bursts, and the burst rate is redrawn from three
  // settings, one of them zero, so that some stretches see no backpressure at all.
  always @(negedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 256 == 0) begin
      case ($urandom_range(0, 2))
        0: stall_pct <= 0;
        1: stall_pct <= 12;
        default: stall_pct <= 35;
      endcase
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      hold_left <= $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Every output word taken at a rising edge is checked against the ledger.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      ledger.check(timer_word_t'{out_status, out_compare_value, out_compare_enable,
                                 out_entry_count});
  end

  // Presents one input word at a falling edge and holds it until the block takes it.
  // The caller stands at a falling edge; the task returns at one. It may add an idle
  // burst afterwards so that gaps land on both the accept and the execute step of the block.
  task automatic send_word(logic mode, logic [RSN_W-1:0] rsn, logic [IVL_W-1:0] ivl,
                           logic [DL_W-1:0] now);
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_reason   <= rsn;
    in_interval <= ivl;
    in_now      <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.book(mode, rsn, ivl, now);
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  // Holds the input idle until every booked word has come back.
  task automatic wait_empty();
    in_valid <= 1'b0;
    while (ledger.awaited.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic             mode;
    logic [RSN_W-1:0] rsn;
    logic [IVL_W-1:0] ivl;
    logic [DL_W-1:0]  now;
    logic [DL_W-1:0]  clock_now;
    int               start_pct;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_mode     = MODE_START;
    in_reason   = '0;
    in_interval = '0;
    in_now      = '0;
    out_stall   = 1'b0;
    hold_left   = 0;
    cycle_cnt   = 0;
    stall_pct   = 12;
    idle_pct    = 20;
    calm        = 1'b0;
    clock_now   = '0;
    start_pct   = 50;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: walk through each corner of insert and remove.
    // A stop on an empty queue finds nothing.
    send_word(MODE_STOP, 8'h10, '0, '0);
    // The only timer is stopped: the enable drops but the compare value stays put.
    send_word(MODE_START, 8'h00, 31'h1234, 32'h0);
    send_word(MODE_STOP, 8'h00, '0, '0);
    // A fresh head, then a tail whose deadline wraps past 2^32.
    send_word(MODE_START, 8'h00, 31'h100, 32'h1000);
    send_word(MODE_START, 8'hff, 31'h7fff_ffff, 32'hffff_ffff);
    // An earlier deadline displaces the head and reloads the compare register.
    send_word(MODE_START, 8'hef, '0, '0);
    // An equal deadline is filed after the timer already holding it.
    send_word(MODE_START, 8'h55, '0, 32'h1200);
    // Stop of an unknown reason, then of a middle entry, then of the head.
    send_word(MODE_STOP, 8'h77, '0, '0);
    send_word(MODE_STOP, 8'h55, '0, '0);
    send_word(MODE_STOP, 8'hef, '0, '0);
    // Fill the queue with repeating reasons and tied deadlines, then overflow it.
    for (int k = 0; k < QUEUE_DEPTH - 1; k++)
      send_word(MODE_START, RSN_W'(k % 8), IVL_W'(32'h80 * (k % 5)), 32'h1000);

    // Let everything come back before the random part starts.
    wait_empty();

    // Random part. The mix of starts and stops shifts every hundred words so that
    // the queue wanders between empty and full. Reasons mostly come from a small
    // pool so that stops usually hit, sometimes with several candidates.
    for (int i = 0; i < 1500; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: start_pct = 30;
          1: start_pct = 50;
          default: start_pct = 75;
        endcase
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end
      if (i == 750) wait_empty();
      if (i == 1300) calm = 1'b1;

      mode = ($urandom_range(0, 99) < start_pct) ? MODE_START : MODE_STOP;
      rsn  = ($urandom_range(0, 3) == 0) ? RSN_W'($urandom) : RSN_W'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0: ivl = IVL_W'($urandom_range(0, 15));
        1: ivl = IVL_W'($urandom_range(0, 4095));
        2: ivl = IVL_W'($urandom);
        default: ivl = 31'h7fff_ffff - IVL_W'($urandom_range(0, 3));
      endcase
      // Time mostly moves forward slowly, so deadlines tie and interleave; now and
      // then it jumps anywhere, including just below the wrap point.
      clock_now = clock_now + DL_W'($urandom_range(0, 64));
      case ($urandom_range(0, 7))
        0: now = $urandom;
        1: now = 32'hffff_ffff - DL_W'($urandom_range(0, 255));
        default: now = clock_now;
      endcase
      send_word(mode, rsn, ivl, now);
    end

    wait_empty();
    repeat (8) @(posedge clk);
    if (ledger.faults == 0 && ledger.awaited.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run with every burst at full length.
  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
